>>> design/brc_pkg.sv
// Shared types and constants of the block request coalescer.
`default_nettype none

package brc_pkg;

  localparam int unsigned FILE_W = 32;
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned LEN_W  = 6;

  // Longest run kept open; a run that grows past it is issued at once.
  localparam int unsigned MAX_RUN = 32;
  localparam logic [LEN_W-1:0] MAX_RUN_LEN = LEN_W'(MAX_RUN);

  // Operation codes of a request beat.
  localparam logic OP_QUEUE = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic              op;
    logic [FILE_W-1:0] file_id;
    logic [BLK_W-1:0]  block_num;
    logic              is_async;
    logic              access_kind;
  } req_t;

  typedef struct packed {
    logic              is_prefetch;
    logic [FILE_W-1:0] run_file;
    logic [BLK_W-1:0]  run_first;
    logic [LEN_W-1:0]  run_length;
    logic              run_kind;
    logic              last;
  } rsp_t;

  // Request held in the input register.
  typedef struct packed {
    logic valid;
    req_t req;
  } req_stage_t;

  // Run issued by the tracker in the current cycle.
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } rsp_stage_t;

endpackage

`default_nettype wire

>>> design/brc_req_if.sv
// Request channel: one block request or flush per beat.
`default_nettype none

interface brc_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [brc_pkg::FILE_W-1:0]  file_id;
  logic [brc_pkg::BLK_W-1:0]   block_num;
  logic                        is_async;
  logic                        access_kind;

  modport source (output valid, op, file_id, block_num, is_async, access_kind,
                  input ready);
  modport sink   (input valid, op, file_id, block_num, is_async, access_kind,
                  output ready);
endinterface

`default_nettype wire

>>> design/brc_rsp_if.sv
// Response channel: one coalesced run per beat.
`default_nettype none

interface brc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        is_prefetch;
  logic [brc_pkg::FILE_W-1:0]  run_file;
  logic [brc_pkg::BLK_W-1:0]   run_first;
  logic [brc_pkg::LEN_W-1:0]   run_length;
  logic                        run_kind;
  logic                        last;

  modport source (output valid, is_prefetch, run_file, run_first, run_length,
                  run_kind, last, input ready);
  modport sink   (input valid, is_prefetch, run_file, run_first, run_length,
                  run_kind, last, output ready);
endinterface

`default_nettype wire

>>> design/brc_in_stage.sv
// Input register of the coalescer: holds one request beat.
`default_nettype none

module brc_in_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  brc_req_if.sink                  req,
  input  wire logic                advance,
  output brc_pkg::req_stage_t      stage
);

  logic         held;
  logic         held_next;
  brc_pkg::req_t data;
  logic         accept;

  assign req.ready = !held || advance;
  assign accept    = req.valid && req.ready;

  always_comb begin
    held_next = held;
    if (accept) begin
      held_next = 1'b1;
    end else if (advance) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data.op          <= req.op;
      data.file_id     <= req.file_id;
      data.block_num   <= req.block_num;
      data.is_async    <= req.is_async;
      data.access_kind <= req.access_kind;
    end
  end

  assign stage.valid = held;
  assign stage.req   = data;

endmodule

`default_nettype wire

>>> design/brc_run_tracker.sv
// Open-run registers and the merge/close decision for one request.
`default_nettype none

module brc_run_tracker #(
  parameter int unsigned MAX_RUN = brc_pkg::MAX_RUN
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire brc_pkg::req_stage_t stage,
  input  wire logic                advance,
  output brc_pkg::rsp_stage_t      issue
);

  // Longest run kept open, at the width of the block count.
  localparam logic [brc_pkg::LEN_W-1:0] MAX_LEN = brc_pkg::LEN_W'(MAX_RUN);

  logic                         open_valid;
  logic                         open_valid_next;
  logic [brc_pkg::LEN_W-1:0]    open_count;
  logic [brc_pkg::LEN_W-1:0]    open_count_next;
  logic [brc_pkg::FILE_W-1:0]   open_file;
  logic [brc_pkg::BLK_W-1:0]    open_first;
  logic [brc_pkg::BLK_W-1:0]    open_last;
  logic                         open_async;
  logic                         open_kind;
  logic [brc_pkg::BLK_W-1:0]    open_first_next;
  logic                         open_async_next;

  logic                         fire;
  logic                         is_flush;
  logic                         joins;
  logic                         close_old;
  logic                         close_new;
  logic [brc_pkg::LEN_W-1:0]    grown_count;

  assign fire     = stage.valid && advance;
  assign is_flush = (stage.req.op == brc_pkg::OP_FLUSH);

  // Block extends the open run: same file, next block, and not sync into async.
  assign joins = open_valid
              && (stage.req.file_id == open_file)
              && (stage.req.block_num == open_last + brc_pkg::BLK_W'(1))
              && !(open_async && !stage.req.is_async);

  assign close_old       = open_valid && !joins;
  assign grown_count     = (joins ? open_count : '0) + brc_pkg::LEN_W'(1);
  assign close_new       = grown_count > MAX_LEN;
  assign open_first_next = joins ? open_first : stage.req.block_num;
  assign open_async_next = joins ? (open_async & stage.req.is_async)
                                 : stage.req.is_async;

  // A new run of one block never exceeds the limit, so at most one run
  // leaves per request.
  always_comb begin
    issue.valid           = 1'b0;
    issue.rsp.is_prefetch = open_async;
    issue.rsp.run_file    = open_file;
    issue.rsp.run_first   = open_first;
    issue.rsp.run_length  = open_count;
    issue.rsp.run_kind    = open_kind;
    issue.rsp.last        = 1'b1;
    if (stage.valid) begin
      if (is_flush) begin
        issue.valid = open_valid;
      end else if (close_old) begin
        issue.valid = 1'b1;
      end else if (close_new) begin
        issue.valid           = 1'b1;
        issue.rsp.is_prefetch = open_async_next;
        issue.rsp.run_file    = stage.req.file_id;
        issue.rsp.run_first   = open_first_next;
        issue.rsp.run_length  = grown_count;
        issue.rsp.run_kind    = stage.req.access_kind;
      end
    end
  end

  always_comb begin
    open_valid_next = open_valid;
    open_count_next = open_count;
    if (fire) begin
      if (is_flush) begin
        open_valid_next = 1'b0;
        open_count_next = '0;
      end else begin
        open_valid_next = !close_new;
        open_count_next = close_new ? '0 : grown_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid <= 1'b0;
      open_count <= '0;
    end else begin
      open_valid <= open_valid_next;
      open_count <= open_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !is_flush) begin
      open_file  <= stage.req.file_id;
      open_first <= open_first_next;
      open_last  <= stage.req.block_num;
      open_async <= open_async_next;
      open_kind  <= stage.req.access_kind;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    open_count <= MAX_LEN)
    else $error("open run longer than the limit");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    open_valid == (open_count != '0))
    else $error("open run mark and block count disagree");

  a_issue_len: assert property (@(posedge clk) disable iff (rst)
    issue.valid |-> (issue.rsp.run_length != '0))
    else $error("issued run with zero length");

  a_join_grows: assert property (@(posedge clk) disable iff (rst)
    (fire && !is_flush && joins && !close_new) |=> (open_count == $past(open_count) + 1'b1))
    else $error("merged block did not grow the run");
`endif

endmodule

`default_nettype wire

>>> design/brc_out_stage.sv
// Result register of the coalescer: holds one run beat for the receiver.
`default_nettype none

module brc_out_stage (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire brc_pkg::rsp_stage_t issue,
  input  wire logic                load,
  output logic                     free,
  brc_rsp_if.source                rsp
);

  logic          held;
  logic          held_next;
  brc_pkg::rsp_t data;

  assign free = !held || rsp.ready;

  always_comb begin
    held_next = held;
    if (load && issue.valid) begin
      held_next = 1'b1;
    end else if (rsp.ready) begin
      held_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load && issue.valid) begin
      data <= issue.rsp;
    end
  end

  assign rsp.valid       = held;
  assign rsp.is_prefetch = data.is_prefetch;
  assign rsp.run_file    = data.run_file;
  assign rsp.run_first   = data.run_first;
  assign rsp.run_length  = data.run_length;
  assign rsp.run_kind    = data.run_kind;
  assign rsp.last        = data.last;

endmodule

`default_nettype wire

>>> design/block_request_coalescer.sv
// Top level of the block request coalescer.
//
// Usage:
//   req carries one beat per block request: op selects queue or flush,
//   file_id/block_num name the block, is_async marks a prefetch block and
//   access_kind travels to the issued run. Queued blocks of one file with
//   consecutive numbers merge into one open run; a run is issued on rsp
//   when a block breaks it, when it grows past MAX_RUN blocks, or
//   on a flush. Each rsp beat is one run, with last set.
//   Throughput: one req beat per cycle, sustained while rsp is taken, set by the
//   combinational merge/close logic between the input register and the result
//   register. A run caused by an accepted req beat passes the input register,
//   then the result register, before it is shown on rsp.
//   A beat that closes nothing (merge, or flush with no open run) leaves no
//   rsp beat.
//   Stall: while rsp is held and not taken, the input register still takes
//   one more req beat; beyond that req.ready drops until rsp moves.
//   Reset (rst, synchronous): drop any open run and empty both registers.
`default_nettype none

module block_request_coalescer #(
  parameter int unsigned MAX_RUN = brc_pkg::MAX_RUN
) (
  input  wire logic   clk,
  input  wire logic   rst,
  brc_req_if.sink     req,
  brc_rsp_if.source   rsp
);

  brc_pkg::req_stage_t stage;
  brc_pkg::rsp_stage_t issue;
  logic                out_free;

  // Advance the held request whenever the result register can take a beat.
  brc_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .advance (out_free),
    .stage   (stage)
  );

  // Merge or close against the open run.
  brc_run_tracker #(
    .MAX_RUN (MAX_RUN)
  ) u_track (
    .clk     (clk),
    .rst     (rst),
    .stage   (stage),
    .advance (out_free),
    .issue   (issue)
  );

  // Hold the issued run until the receiver takes it.
  brc_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .load  (out_free),
    .free  (out_free),
    .rsp   (rsp)
  );

endmodule

`default_nettype wire
